>>> rtl/mwcm_pkg.sv
package mwcm_pkg;

    localparam int unsigned ANGLE_TABLE_BITS = 10;
    localparam int unsigned ANGLE_QUARTER    = 1 << (ANGLE_TABLE_BITS - 2);

    localparam int unsigned FULL_TURN        = 46080;
    localparam int unsigned HALF_TURN        = FULL_TURN / 2;
    localparam int unsigned ANG_U_W          = 17;
    localparam int unsigned KNUM_W           = ANG_U_W + ANGLE_TABLE_BITS;
    localparam int unsigned KQ_W             = ANGLE_TABLE_BITS + 1;
    localparam int unsigned RECIP_SHIFT      = 32;
    localparam longint unsigned RECIP        = (64'd1 << RECIP_SHIFT) / FULL_TURN;
    localparam int unsigned RECIP_W          = $clog2(RECIP + 1);
    localparam int unsigned KPROD_W          = KNUM_W + RECIP_W;

    localparam longint unsigned PI_HALF_Q30  = 64'd1686629713;
    localparam int unsigned SIN_MAG_W        = 15;
    localparam int unsigned SIN_W            = 16;

    localparam int unsigned SQ_W             = 31;
    localparam int unsigned FOLLOW_SHIFT     = 13;
    localparam int unsigned FOLLOW_ROUND     = 1 << (FOLLOW_SHIFT - 1);
    localparam int unsigned W_W              = 19;

    localparam int unsigned ROT_W            = 32;
    localparam int unsigned MIX_W            = 36;
    localparam int unsigned TIER_W           = 3;
    localparam int unsigned VN_W             = 38;
    localparam int unsigned MAG_W            = 37;
    localparam int unsigned LIMIT_W          = 15;
    localparam int unsigned PROD_W           = MAG_W + LIMIT_W;
    localparam int unsigned TIER_UNIT        = 327680;

    localparam int unsigned DIV_NUM_W        = 54;
    localparam int unsigned DIV_DEN_W        = 38;
    localparam int unsigned DIV_STEPS        = 16;
    localparam int unsigned WHEEL_W          = 16;

    localparam int unsigned PRE_STAGES       = 11;
    localparam int unsigned VLD_N            = PRE_STAGES + DIV_STEPS;
    localparam int unsigned SIDE_N           = PRE_STAGES + DIV_STEPS - 2;
    localparam int unsigned PIPE_LAT         = PRE_STAGES + DIV_STEPS + 1;

    localparam int unsigned BUF_LOW          = 10;
    localparam int unsigned BUF_MID          = 30;
    localparam int unsigned BUF_HIGH         = 60;
    localparam logic [TIER_W-1:0] TIER_FULL  = 3'd5;
    localparam logic [TIER_W-1:0] TIER_LOW   = 3'd1;
    localparam logic [TIER_W-1:0] TIER_MID   = 3'd2;
    localparam logic [TIER_W-1:0] TIER_HIGH  = 3'd3;

    localparam int unsigned CFG_IDX_W        = 3;
    localparam int unsigned CFG_DATA_W       = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_LF   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_RF   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_LB   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_RB   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPIN_RATE = 3'd5;

    localparam logic [15:0] COEF_RESET       = 16'd458;
    localparam logic [LIMIT_W-1:0] MAX_RESET = 15'd21200;
    localparam logic [15:0] SPIN_RESET       = 16'd1100;

    typedef enum logic [1:0] {
        MODE_ZERO   = 2'd0,
        MODE_FREE   = 2'd1,
        MODE_FOLLOW = 2'd2,
        MODE_ROTATE = 2'd3
    } t_mode;

    typedef struct packed {
        logic signed [15:0] speed_x;
        logic signed [15:0] speed_y;
        logic signed [15:0] spin_cmd;
        logic signed [15:0] yaw_offset;
        t_mode              mode;
        logic [9:0]         energy_left;
        logic [9:0]         power_cap;
    } t_cmd;

    typedef struct packed {
        logic signed [15:0] wheel_left_front;
        logic signed [15:0] wheel_right_front;
        logic signed [15:0] wheel_left_back;
        logic signed [15:0] wheel_right_back;
        logic               motors_enabled;
        logic signed [31:0] spin_used;
    } t_result;

    typedef struct packed {
        logic                  en;
        logic signed [W_W-1:0] w;
    } t_side;

    typedef logic [SIN_MAG_W-1:0] t_sin_tab [ANGLE_QUARTER+1];

    function automatic t_sin_tab f_sin_tab();
        t_sin_tab          tab;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   term;
        longint            sum;
        for (int j = 0; j <= int'(ANGLE_QUARTER); j++) begin
            x = (PI_HALF_Q30 * longint'(j) + (64'd1 << (ANGLE_TABLE_BITS - 3)))
                >> (ANGLE_TABLE_BITS - 2);
            x2 = (x * x) >> 30;
            sum = longint'(x);
            term = ((x * x2) >> 30) / 6;
            sum = sum - longint'(term);
            term = ((term * x2) >> 30) / 20;
            sum = sum + longint'(term);
            term = ((term * x2) >> 30) / 42;
            sum = sum - longint'(term);
            term = ((term * x2) >> 30) / 72;
            sum = sum + longint'(term);
            term = ((term * x2) >> 30) / 110;
            sum = sum - longint'(term);
            term = ((term * x2) >> 30) / 156;
            sum = sum + longint'(term);
            if (sum < 0) begin
                sum = 0;
            end
            sum = (sum + 32768) >>> 16;
            if (sum > 16384) begin
                sum = 16384;
            end
            tab[j] = SIN_MAG_W'(sum);
        end
        return tab;
    endfunction

    localparam t_sin_tab SIN_TAB = f_sin_tab();

    function automatic logic signed [SIN_W-1:0] f_wave(input logic [ANGLE_TABLE_BITS-1:0] k);
        logic [1:0]                    quad;
        logic [ANGLE_TABLE_BITS-2:0]   r;
        logic [ANGLE_TABLE_BITS-2:0]   idx;
        logic [SIN_MAG_W-1:0]          mag;
        quad = k[ANGLE_TABLE_BITS-1:ANGLE_TABLE_BITS-2];
        r    = {1'b0, k[ANGLE_TABLE_BITS-3:0]};
        idx  = quad[0] ? (ANGLE_TABLE_BITS-1)'(ANGLE_QUARTER) - r : r;
        mag  = SIN_TAB[idx];
        return quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

endpackage

>>> rtl/mwcm_div.sv
module mwcm_div (
    input  logic                                  i_clk,
    input  logic [mwcm_pkg::DIV_NUM_W-1:0]        i_num,
    input  logic [mwcm_pkg::DIV_DEN_W-1:0]        i_den,
    input  logic                                  i_neg,
    output logic signed [mwcm_pkg::WHEEL_W-1:0]   o_quot
);

    logic [mwcm_pkg::DIV_NUM_W-1:0] r_rem   [mwcm_pkg::DIV_STEPS];
    logic [mwcm_pkg::DIV_DEN_W-1:0] r_den   [mwcm_pkg::DIV_STEPS];
    logic [mwcm_pkg::DIV_STEPS-1:0] r_quo   [mwcm_pkg::DIV_STEPS];
    logic                           r_neg   [mwcm_pkg::DIV_STEPS];
    logic [mwcm_pkg::DIV_NUM_W-1:0] n_rem   [mwcm_pkg::DIV_STEPS];
    logic [mwcm_pkg::DIV_STEPS-1:0] n_quo   [mwcm_pkg::DIV_STEPS];
    logic [mwcm_pkg::DIV_NUM_W-1:0] cur_rem [mwcm_pkg::DIV_STEPS];
    logic [mwcm_pkg::DIV_DEN_W-1:0] cur_den [mwcm_pkg::DIV_STEPS];
    logic [mwcm_pkg::DIV_STEPS-1:0] cur_quo [mwcm_pkg::DIV_STEPS];
    logic                           cur_neg [mwcm_pkg::DIV_STEPS];
    logic [mwcm_pkg::DIV_NUM_W-1:0] trial   [mwcm_pkg::DIV_STEPS];

    // one restoring step per stage, quotient msb first
    always_comb begin
        cur_rem[0] = i_num;
        cur_den[0] = i_den;
        cur_quo[0] = '0;
        cur_neg[0] = i_neg;
        for (int j = 1; j < int'(mwcm_pkg::DIV_STEPS); j++) begin
            cur_rem[j] = r_rem[j-1];
            cur_den[j] = r_den[j-1];
            cur_quo[j] = r_quo[j-1];
            cur_neg[j] = r_neg[j-1];
        end
        for (int j = 0; j < int'(mwcm_pkg::DIV_STEPS); j++) begin
            trial[j] = mwcm_pkg::DIV_NUM_W'(cur_den[j]) << (mwcm_pkg::DIV_STEPS - 1 - j);
            if (cur_rem[j] >= trial[j]) begin
                n_rem[j] = cur_rem[j] - trial[j];
                n_quo[j] = cur_quo[j]
                         | (mwcm_pkg::DIV_STEPS'(1) << (mwcm_pkg::DIV_STEPS - 1 - j));
            end else begin
                n_rem[j] = cur_rem[j];
                n_quo[j] = cur_quo[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < int'(mwcm_pkg::DIV_STEPS); j++) begin
            r_rem[j] <= n_rem[j];
            r_den[j] <= cur_den[j];
            r_quo[j] <= n_quo[j];
            r_neg[j] <= cur_neg[j];
        end
    end

    assign o_quot = r_neg[mwcm_pkg::DIV_STEPS-1]
                  ? -$signed(r_quo[mwcm_pkg::DIV_STEPS-1])
                  : $signed(r_quo[mwcm_pkg::DIV_STEPS-1]);

endmodule

>>> rtl/mecanum_wheel_command_mixer_core.sv
// Mecanum command mixer: takes one chassis command per cycle and returns four wheel speed
// references, one result per command, in order. There is no back-pressure: o_busy is low
// outside reset and o_done pulses for one cycle with each result, which must be captured
// then. The pipeline is 11 arithmetic stages (angle reduction, table lookup, rotation, mix,
// tiering, limit) and a 16-stage restoring divider that does the final rounded scaling.
// Configuration writes are always ready and should be made while idle.
module mecanum_wheel_command_mixer_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    output logic                                 o_busy,
    input  mwcm_pkg::t_cmd                       i_cmd,
    output logic                                 o_done,
    output mwcm_pkg::t_result                    o_result,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [mwcm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mwcm_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int unsigned TB = mwcm_pkg::ANGLE_TABLE_BITS;

    logic [15:0]                          r_coef [4];
    logic [mwcm_pkg::LIMIT_W-1:0]         r_max;
    logic signed [15:0]                   r_spin;

    logic [mwcm_pkg::VLD_N-1:0]           r_vld;
    logic                                 r_done;
    mwcm_pkg::t_result                    r_res;
    mwcm_pkg::t_cmd                       r_cmd [5];
    mwcm_pkg::t_side                      r_side [mwcm_pkg::SIDE_N];

    logic [mwcm_pkg::SQ_W-1:0]            r1_sq;
    logic [mwcm_pkg::KNUM_W-1:0]          r1_num;
    logic [mwcm_pkg::KNUM_W-1:0]          r2_num;
    logic [mwcm_pkg::KQ_W-1:0]            r2_q0;
    logic [TB-1:0]                        r3_k;
    logic signed [mwcm_pkg::SIN_W-1:0]    r4_s;
    logic signed [mwcm_pkg::SIN_W-1:0]    r4_c;
    logic signed [mwcm_pkg::ROT_W-1:0]    r5_xs, r5_xc, r5_ys, r5_yc;
    logic signed [mwcm_pkg::MIX_W-1:0]    r5_wc [4];
    logic [mwcm_pkg::TIER_W-1:0]          r5_n;
    logic signed [mwcm_pkg::MIX_W-1:0]    r6_v [4];
    logic [mwcm_pkg::TIER_W-1:0]          r6_n;
    logic signed [mwcm_pkg::VN_W-1:0]     r7_v [4];
    logic [mwcm_pkg::MAG_W-1:0]           r8_mag [4];
    logic                                 r8_neg [4];
    logic [mwcm_pkg::MAG_W-1:0]           r8_m;
    logic [mwcm_pkg::PROD_W-1:0]          r9_prod [4];
    logic [mwcm_pkg::MAG_W-1:0]           r9_mag [4];
    logic                                 r9_neg [4];
    logic [mwcm_pkg::MAG_W-1:0]           r9_m;
    logic                                 r9_comp;
    logic [mwcm_pkg::DIV_NUM_W-1:0]       r10_num [4];
    logic                                 r10_neg [4];
    logic [mwcm_pkg::DIV_DEN_W-1:0]       r10_den;

    logic signed [16:0]                   ang_x;
    logic [16:0]                          ang_abs;
    logic [33:0]                          sq_full;
    logic [mwcm_pkg::ANG_U_W-1:0]         ang_u;
    logic [mwcm_pkg::SQ_W-1:0]            fol_sum;
    logic signed [mwcm_pkg::W_W-1:0]      fol_w;
    logic [mwcm_pkg::KPROD_W-1:0]         kprod;
    logic [mwcm_pkg::KNUM_W-1:0]          krem;
    logic [mwcm_pkg::KQ_W-1:0]            kq;
    logic signed [mwcm_pkg::MIX_W-1:0]    cx, cy;
    logic [mwcm_pkg::MAG_W-1:0]           m01, m23;
    logic                                 accept;

    logic [mwcm_pkg::SQ_W-1:0]            n1_sq;
    logic [mwcm_pkg::KNUM_W-1:0]          n1_num;
    logic signed [mwcm_pkg::W_W-1:0]      n2_w;
    logic [mwcm_pkg::KQ_W-1:0]            n2_q0;
    logic [TB-1:0]                        n3_k;
    logic [mwcm_pkg::TIER_W-1:0]          n5_n;
    logic signed [mwcm_pkg::MIX_W-1:0]    n5_wc [4];
    logic signed [mwcm_pkg::MIX_W-1:0]    n6_v [4];
    logic signed [mwcm_pkg::VN_W-1:0]     n7_v [4];
    logic [mwcm_pkg::MAG_W-1:0]           n8_mag [4];
    logic [mwcm_pkg::MAG_W-1:0]           n8_m;
    logic [mwcm_pkg::DIV_NUM_W-1:0]       n10_num [4];
    logic [mwcm_pkg::DIV_DEN_W-1:0]       n10_den;
    logic signed [mwcm_pkg::WHEEL_W-1:0]  quot [4];

    assign o_busy      = !i_rst_n;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_coef[i] <= mwcm_pkg::COEF_RESET;
            end
            r_max  <= mwcm_pkg::MAX_RESET;
            r_spin <= mwcm_pkg::SPIN_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mwcm_pkg::CFG_COEF_LF:   r_coef[0] <= i_cfg_data;
                mwcm_pkg::CFG_COEF_RF:   r_coef[1] <= i_cfg_data;
                mwcm_pkg::CFG_COEF_LB:   r_coef[2] <= i_cfg_data;
                mwcm_pkg::CFG_COEF_RB:   r_coef[3] <= i_cfg_data;
                mwcm_pkg::CFG_MAX_SPEED: r_max     <= i_cfg_data[mwcm_pkg::LIMIT_W-1:0];
                mwcm_pkg::CFG_SPIN_RATE: r_spin    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        // spin square and angle index numerator
        ang_x   = {r_cmd[0].yaw_offset[15], r_cmd[0].yaw_offset};
        ang_abs = 17'(ang_x < 0 ? -ang_x : ang_x);
        sq_full = 34'(ang_abs) * 34'(ang_abs);
        n1_sq   = sq_full[mwcm_pkg::SQ_W-1:0];
        ang_u   = 17'(ang_x) + 17'(mwcm_pkg::FULL_TURN);
        n1_num  = {ang_u, {TB{1'b0}}} + mwcm_pkg::KNUM_W'(mwcm_pkg::HALF_TURN);

        // spin select, reciprocal estimate of the index
        fol_sum = r1_sq + mwcm_pkg::SQ_W'(mwcm_pkg::FOLLOW_ROUND);
        fol_w   = r_cmd[1].yaw_offset[15]
                ? -$signed({1'b0, fol_sum[mwcm_pkg::SQ_W-1:mwcm_pkg::FOLLOW_SHIFT]})
                : $signed({1'b0, fol_sum[mwcm_pkg::SQ_W-1:mwcm_pkg::FOLLOW_SHIFT]});
        unique case (r_cmd[1].mode)
            mwcm_pkg::MODE_FOLLOW: n2_w = fol_w;
            mwcm_pkg::MODE_ROTATE: n2_w = mwcm_pkg::W_W'(r_spin);
            mwcm_pkg::MODE_ZERO,
            mwcm_pkg::MODE_FREE:   n2_w = mwcm_pkg::W_W'(r_cmd[1].spin_cmd);
            default:               n2_w = mwcm_pkg::W_W'(r_cmd[1].spin_cmd);
        endcase
        kprod = mwcm_pkg::KPROD_W'(r1_num) * mwcm_pkg::KPROD_W'(mwcm_pkg::RECIP);
        n2_q0 = kprod[mwcm_pkg::RECIP_SHIFT +: mwcm_pkg::KQ_W];

        // estimate is low by at most one
        krem = r2_num - mwcm_pkg::KNUM_W'(mwcm_pkg::KNUM_W'(r2_q0)
                                           * mwcm_pkg::KNUM_W'(mwcm_pkg::FULL_TURN));
        kq   = r2_q0 + mwcm_pkg::KQ_W'(krem >= mwcm_pkg::KNUM_W'(mwcm_pkg::FULL_TURN));
        n3_k = kq[TB-1:0];

        priority if (r_cmd[4].power_cap == '0) begin
            n5_n = mwcm_pkg::TIER_FULL;
        end else if (r_cmd[4].energy_left < 10'(mwcm_pkg::BUF_LOW)) begin
            n5_n = mwcm_pkg::TIER_LOW;
        end else if (r_cmd[4].energy_left < 10'(mwcm_pkg::BUF_MID)) begin
            n5_n = mwcm_pkg::TIER_MID;
        end else if (r_cmd[4].energy_left < 10'(mwcm_pkg::BUF_HIGH)) begin
            n5_n = mwcm_pkg::TIER_HIGH;
        end else begin
            n5_n = mwcm_pkg::TIER_FULL;
        end
        for (int i = 0; i < 4; i++) begin
            n5_wc[i] = mwcm_pkg::MIX_W'(r_side[2].w)
                     * mwcm_pkg::MIX_W'($signed({1'b0, r_coef[i]}));
        end

        cy = (mwcm_pkg::MIX_W'(r5_xs) + mwcm_pkg::MIX_W'(r5_yc)) <<< 2;
        cx = (mwcm_pkg::MIX_W'(r5_xc) - mwcm_pkg::MIX_W'(r5_ys)) <<< 2;
        n6_v[0] = cx - cy - r5_wc[0];
        n6_v[1] = cx + cy + r5_wc[1];
        n6_v[2] = cx + cy - r5_wc[2];
        n6_v[3] = cx - cy + r5_wc[3];

        for (int i = 0; i < 4; i++) begin
            n7_v[i]   = mwcm_pkg::VN_W'(r6_v[i]) * mwcm_pkg::VN_W'($signed({1'b0, r6_n}));
            n8_mag[i] = mwcm_pkg::MAG_W'(r7_v[i][mwcm_pkg::VN_W-1] ? -r7_v[i] : r7_v[i]);
        end
        m01  = (n8_mag[0] > n8_mag[1]) ? n8_mag[0] : n8_mag[1];
        m23  = (n8_mag[2] > n8_mag[3]) ? n8_mag[2] : n8_mag[3];
        n8_m = (m01 > m23) ? m01 : m23;

        // rounded quotient: (2|v|L + M) / 2M when compressing, else (2|v| + T) / 2T
        for (int i = 0; i < 4; i++) begin
            n10_num[i] = r9_comp
                       ? (mwcm_pkg::DIV_NUM_W'(r9_prod[i]) << 1) + mwcm_pkg::DIV_NUM_W'(r9_m)
                       : (mwcm_pkg::DIV_NUM_W'(r9_mag[i]) << 1)
                         + mwcm_pkg::DIV_NUM_W'(mwcm_pkg::TIER_UNIT);
        end
        n10_den = r9_comp ? mwcm_pkg::DIV_DEN_W'(r9_m) << 1
                          : mwcm_pkg::DIV_DEN_W'(2 * mwcm_pkg::TIER_UNIT);
    end

    always_ff @(posedge i_clk) begin
        r_cmd[0] <= i_cmd;
        for (int s = 1; s < 5; s++) begin
            r_cmd[s] <= r_cmd[s-1];
        end
        r_side[0] <= '{en: (r_cmd[1].mode != mwcm_pkg::MODE_ZERO), w: n2_w};
        for (int s = 1; s < int'(mwcm_pkg::SIDE_N); s++) begin
            r_side[s] <= r_side[s-1];
        end

        r1_sq  <= n1_sq;
        r1_num <= n1_num;
        r2_num <= r1_num;
        r2_q0  <= n2_q0;
        r3_k   <= n3_k;
        r4_s   <= mwcm_pkg::f_wave(r3_k);
        r4_c   <= mwcm_pkg::f_wave(r3_k + TB'(mwcm_pkg::ANGLE_QUARTER));
        r5_xs  <= mwcm_pkg::ROT_W'(r_cmd[4].speed_x) * mwcm_pkg::ROT_W'(r4_s);
        r5_xc  <= mwcm_pkg::ROT_W'(r_cmd[4].speed_x) * mwcm_pkg::ROT_W'(r4_c);
        r5_ys  <= mwcm_pkg::ROT_W'(r_cmd[4].speed_y) * mwcm_pkg::ROT_W'(r4_s);
        r5_yc  <= mwcm_pkg::ROT_W'(r_cmd[4].speed_y) * mwcm_pkg::ROT_W'(r4_c);
        r5_n   <= n5_n;
        r6_n   <= r5_n;
        for (int i = 0; i < 4; i++) begin
            r5_wc[i]   <= n5_wc[i];
            r6_v[i]    <= n6_v[i];
            r7_v[i]    <= n7_v[i];
            r8_mag[i]  <= n8_mag[i];
            r8_neg[i]  <= r7_v[i][mwcm_pkg::VN_W-1];
            r9_prod[i] <= mwcm_pkg::PROD_W'(r8_mag[i]) * mwcm_pkg::PROD_W'(r_max);
            r9_mag[i]  <= r8_mag[i];
            r9_neg[i]  <= r8_neg[i];
            r10_num[i] <= n10_num[i];
            r10_neg[i] <= r9_neg[i];
        end
        r8_m    <= n8_m;
        r9_m    <= r8_m;
        r9_comp <= r8_m > mwcm_pkg::MAG_W'(mwcm_pkg::MAG_W'(r_max)
                                          * mwcm_pkg::MAG_W'(mwcm_pkg::TIER_UNIT));
        r10_den <= n10_den;

        r_res.wheel_left_front  <= quot[0];
        r_res.wheel_right_front <= quot[1];
        r_res.wheel_left_back   <= quot[2];
        r_res.wheel_right_back  <= quot[3];
        r_res.motors_enabled    <= r_side[mwcm_pkg::SIDE_N-1].en;
        r_res.spin_used         <= 32'(r_side[mwcm_pkg::SIDE_N-1].w);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_done <= 1'b0;
        end else begin
            r_vld  <= {r_vld[mwcm_pkg::VLD_N-2:0], accept};
            r_done <= r_vld[mwcm_pkg::VLD_N-1];
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_div
        mwcm_div u_div (
            .i_clk  (i_clk),
            .i_num  (r10_num[g]),
            .i_den  (r10_den),
            .i_neg  (r10_neg[g]),
            .o_quot (quot[g])
        );
    end

    assign o_done   = r_done;
    assign o_result = r_res;

    a_done_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept, mwcm_pkg::PIPE_LAT))
        else $error("result without a matching item");

    a_item_gives_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##(mwcm_pkg::PIPE_LAT) o_done)
        else $error("item lost in pipeline");

    a_enable_follows_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.motors_enabled
                    == ($past(i_cmd.mode, mwcm_pkg::PIPE_LAT) != mwcm_pkg::MODE_ZERO)))
        else $error("motor enable out of step with mode");

endmodule
